// File: hdl/dsps_pkg.sv
// ----------------------------------------------------------------------------
// dsps_pkg
// Shared types, character codes and helper functions for the debug serial
// packet stub.
// ----------------------------------------------------------------------------
package dsps_pkg;

    // Defaults for the top-level parameters
    localparam int DEFAULT_BUFFER_SIZE    = 1024;
    localparam int DEFAULT_REGISTER_COUNT = 16;
    localparam logic [7:0] STOP_SIGNAL_RESET = 8'h05;

    // Item operation codes
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Protocol characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_G      = 8'h67;

    // Marks a checksum character that is not a hex digit
    localparam logic [4:0] BAD_DIGIT = 5'd16;

    // Output word kinds handed from the sequencer to the output stage
    typedef logic [3:0] kind_t;
    localparam kind_t K_ACK_OK  = 4'd0;
    localparam kind_t K_ACK_BAD = 4'd1;
    localparam kind_t K_DOLLAR  = 4'd2;
    localparam kind_t K_HASH    = 4'd3;
    localparam kind_t K_STOP_S  = 4'd4;
    localparam kind_t K_STOP_HI = 4'd5;
    localparam kind_t K_STOP_LO = 4'd6;
    localparam kind_t K_REG     = 4'd7;
    localparam kind_t K_SUM_HI  = 4'd8;
    localparam kind_t K_SUM_LO  = 4'd9;

    // One issued output word: kind plus nibble select within a register
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [2:0] nib;
    } issue_t;

    // Lowercase hex character for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        else
            return 8'h57 + {4'h0, n};
    endfunction

    // Value of a hex digit character, BAD_DIGIT if it is none
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            return 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            return 5'(c - 8'h37);
        else
            return BAD_DIGIT;
    endfunction

    // Reset contents of the target register file
    function automatic logic [31:0] reg_reset_value(input logic [5:0] idx);
        if (idx < 6'd15)
            return {8{4'(idx + 6'd1)}};
        else if (idx == 6'd15)
            return 32'h12345678;
        else
            return 32'h0;
    endfunction

endpackage

// File: hdl/dsps_ifs.sv
// ----------------------------------------------------------------------------
// dsps_ifs
// Valid/ready channel interfaces: command words in, response words out.
// ----------------------------------------------------------------------------
interface dsps_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface dsps_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       is_ack;
    logic       last;

    modport source (output valid, output tx_byte, output is_ack, output last, input ready);
    modport sink   (input valid, input tx_byte, input is_ack, input last, output ready);
endinterface

// File: hdl/dsps_seq.sv
// ----------------------------------------------------------------------------
// dsps_seq
// Packet parser and reply sequencer. Tracks the receive phase, payload sum and
// reply position, and issues an output word kind when an accepted word ends a
// packet or pulls a reply, plus the register file read address for register dump digits.
// ----------------------------------------------------------------------------
module dsps_seq #(
    parameter int BUFFER_SIZE    = dsps_pkg::DEFAULT_BUFFER_SIZE,
    parameter int REGISTER_COUNT = dsps_pkg::DEFAULT_REGISTER_COUNT
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  logic                                         operation,
    input  logic [7:0]                                   rx_byte,
    output dsps_pkg::issue_t                             issue,
    output logic [(REGISTER_COUNT > 1 ? $clog2(REGISTER_COUNT) : 1)-1:0] rd_addr
);
    import dsps_pkg::*;

    localparam int RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int CNT_W  = $clog2(BUFFER_SIZE);
    localparam int POS_W  = $clog2(REGISTER_COUNT * 8 + 4);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_SIZE - 2);
    localparam logic [POS_W-1:0] LEN_STOP  = POS_W'(3);
    localparam logic [POS_W-1:0] LEN_REGS  = POS_W'(REGISTER_COUNT * 8);

    // Parse phases
    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CSUM_HI = 2'd2;
    localparam logic [1:0] PH_CSUM_LO = 2'd3;

    // Pending reply kinds
    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_STOP  = 2'd1;
    localparam logic [1:0] RK_REGS  = 2'd2;
    localparam logic [1:0] RK_EMPTY = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       psum_reg, psum_next;
    logic [7:0]       first_reg, first_next;
    logic [4:0]       hi_reg, hi_next;
    logic [1:0]       rkind_reg, rkind_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [4:0]       lo_digit;
    logic             csum_ok;
    logic [POS_W-1:0] body_len;
    logic [POS_W-1:0] body_idx;

    assign lo_digit = digit_value(rx_byte);
    assign csum_ok  = (hi_reg != BAD_DIGIT) && (lo_digit != BAD_DIGIT) &&
                      ({hi_reg[3:0], lo_digit[3:0]} == psum_reg);
    assign body_idx = pos_reg - POS_W'(1);
    assign rd_addr  = body_idx[3 +: RIDX_W];

    // Body length of the pending reply
    always_comb
    begin
        case (rkind_reg)
            RK_STOP: body_len = LEN_STOP;
            RK_REGS: body_len = LEN_REGS;
            default: body_len = '0;
        endcase
    end

    // Receive parsing and reply sequencing
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        psum_next  = psum_reg;
        first_next = first_reg;
        hi_next    = hi_reg;
        rkind_next = rkind_reg;
        pos_next   = pos_reg;
        issue      = '0;
        issue.nib  = {body_idx[2:1], ~body_idx[0]};

        if (accept && operation == OP_RX && rkind_reg == RK_NONE)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == CH_DOLLAR)
                    begin
                        phase_next = PH_PAYLOAD;
                        count_next = '0;
                        psum_next  = '0;
                        first_next = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (rx_byte == CH_HASH)
                        phase_next = PH_CSUM_HI;
                    else
                    begin
                        if (count_reg == '0)
                            first_next = rx_byte;
                        psum_next  = psum_reg + rx_byte;
                        count_next = count_reg + CNT_W'(1);
                        // buffer full without '#': drop and hunt again
                        if (count_reg == CNT_LIMIT)
                            phase_next = PH_WAIT;
                    end
                end
                PH_CSUM_HI:
                begin
                    hi_next    = digit_value(rx_byte);
                    phase_next = PH_CSUM_LO;
                end
                PH_CSUM_LO:
                begin
                    phase_next  = PH_WAIT;
                    issue.valid = 1'b1;
                    issue.kind  = csum_ok ? K_ACK_OK : K_ACK_BAD;
                    if (csum_ok)
                    begin
                        pos_next = '0;
                        if (count_reg == '0)
                            rkind_next = RK_EMPTY;
                        else if (first_reg == CH_QUERY || first_reg == CH_C ||
                                 first_reg == CH_LS)
                            rkind_next = RK_STOP;
                        else if (first_reg == CH_G)
                            rkind_next = RK_REGS;
                        else
                            rkind_next = RK_EMPTY;
                    end
                end
            endcase
        end
        else if (accept && operation == OP_PULL && rkind_reg != RK_NONE)
        begin
            issue.valid = 1'b1;
            pos_next    = pos_reg + POS_W'(1);
            if (pos_reg == '0)
                issue.kind = K_DOLLAR;
            else if (pos_reg <= body_len)
            begin
                if (rkind_reg == RK_REGS)
                    issue.kind = K_REG;
                else if (body_idx == '0)
                    issue.kind = K_STOP_S;
                else if (body_idx == POS_W'(1))
                    issue.kind = K_STOP_HI;
                else
                    issue.kind = K_STOP_LO;
            end
            else if (pos_reg == body_len + POS_W'(1))
                issue.kind = K_HASH;
            else if (pos_reg == body_len + POS_W'(2))
                issue.kind = K_SUM_HI;
            else
            begin
                issue.kind = K_SUM_LO;
                rkind_next = RK_NONE;
                pos_next   = '0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
            psum_reg  <= '0;
            first_reg <= '0;
            hi_reg    <= '0;
            rkind_reg <= RK_NONE;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            psum_reg  <= psum_next;
            first_reg <= first_next;
            hi_reg    <= hi_next;
            rkind_reg <= rkind_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: hdl/debug_serial_packet_stub.sv
// ----------------------------------------------------------------------------
// debug_serial_packet_stub
// Byte-level remote debug stub: parses '$'...'#hh' packets, acks or naks
// them, and streams reply packets one word per transmitter pull.
//
//   channel  dir  handshake    payload
//   cmd      in   valid/ready  operation, rx_byte
//   rsp      out  valid/ready  tx_byte, is_ack, last
//   cfg      in   cfg_we       cfg_wdata (stop signal)
//
// One word accepted per cycle while cmd.ready is high; a result is registered
// in the middle stage with its register file read, then in the output register.
// After reset the register file is loaded from its reset table, one entry
// per cycle: cmd.ready stays low until all REGISTER_COUNT entries are loaded.
// A stalled rsp holds the output and mid stages; a full mid stage drops cmd.ready.
// ----------------------------------------------------------------------------
module debug_serial_packet_stub #(
    parameter int BUFFER_SIZE    = dsps_pkg::DEFAULT_BUFFER_SIZE,
    parameter int REGISTER_COUNT = dsps_pkg::DEFAULT_REGISTER_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    dsps_cmd_if.sink          cmd,
    dsps_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata
);
    import dsps_pkg::*;

    localparam int RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int FILL_W = $clog2(REGISTER_COUNT + 1);
    localparam logic [FILL_W-1:0] FILL_DONE = FILL_W'(REGISTER_COUNT);

    logic [7:0]        stop_reg;
    logic [FILL_W-1:0] fill_cnt_reg;
    logic              filling;

    logic              accept;
    issue_t            issue;
    logic [RIDX_W-1:0] rd_addr;

    logic [31:0]       regfile [0:REGISTER_COUNT-1];
    logic [31:0]       rd_data_reg;

    logic              s2_valid_reg;
    kind_t             s2_kind_reg;
    logic [2:0]        s2_nib_reg;
    logic              s2_move;
    logic              out_free;

    logic [7:0]        byte_next;
    logic              add_sum;
    logic [7:0]        sum_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_ack_reg;
    logic              out_last_reg;

    // Handshake
    assign filling   = (fill_cnt_reg != FILL_DONE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s2_move   = s2_valid_reg && out_free;
    assign cmd.ready = !filling && (!s2_valid_reg || out_free);
    assign accept    = cmd.valid && cmd.ready;

    // Stop signal register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stop_reg <= STOP_SIGNAL_RESET;
        else if (cfg_we)
            stop_reg <= cfg_wdata;
    end

    // Parser and reply sequencer
    dsps_seq #(
        .BUFFER_SIZE    (BUFFER_SIZE),
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (cmd.operation),
        .rx_byte   (cmd.rx_byte),
        .issue     (issue),
        .rd_addr   (rd_addr)
    );

    // Register file load after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_cnt_reg <= '0;
        else if (filling)
            fill_cnt_reg <= fill_cnt_reg + FILL_W'(1);
    end

    // Register file memory: write port for the load, registered read
    always_ff @(posedge clk)
    begin
        if (filling)
            regfile[fill_cnt_reg[RIDX_W-1:0]] <= reg_reset_value(6'(fill_cnt_reg));
    end

    always_ff @(posedge clk)
    begin
        if (accept && issue.valid)
            rd_data_reg <= regfile[rd_addr];
    end

    // Middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (accept)
            s2_valid_reg <= issue.valid;
        else if (s2_move)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_kind_reg <= issue.kind;
            s2_nib_reg  <= issue.nib;
        end
    end

    // Output word select
    always_comb
    begin
        add_sum = 1'b0;
        case (s2_kind_reg)
            K_ACK_OK:  byte_next = CH_PLUS;
            K_ACK_BAD: byte_next = CH_MINUS;
            K_DOLLAR:  byte_next = CH_DOLLAR;
            K_HASH:    byte_next = CH_HASH;
            K_STOP_S:
            begin
                byte_next = CH_S;
                add_sum   = 1'b1;
            end
            K_STOP_HI:
            begin
                byte_next = hex_char(stop_reg[7:4]);
                add_sum   = 1'b1;
            end
            K_STOP_LO:
            begin
                byte_next = hex_char(stop_reg[3:0]);
                add_sum   = 1'b1;
            end
            K_REG:
            begin
                byte_next = hex_char(rd_data_reg[{s2_nib_reg, 2'b00} +: 4]);
                add_sum   = 1'b1;
            end
            K_SUM_HI:  byte_next = hex_char(sum_reg[7:4]);
            K_SUM_LO:  byte_next = hex_char(sum_reg[3:0]);
            default:   byte_next = CH_MINUS;
        endcase
    end

    // Reply body checksum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (s2_move && s2_kind_reg == K_SUM_LO)
            sum_reg <= '0;
        else if (s2_move && add_sum)
            sum_reg <= sum_reg + byte_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_move)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_byte_reg <= byte_next;
            out_ack_reg  <= (s2_kind_reg == K_ACK_OK) || (s2_kind_reg == K_ACK_BAD);
            out_last_reg <= (s2_kind_reg == K_SUM_LO);
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.tx_byte = out_byte_reg;
    assign rsp.is_ack  = out_ack_reg;
    assign rsp.last    = out_last_reg;

endmodule
